FILE: src/pss_pkg.sv
package pss_pkg;

   localparam int INDEX_BITS       = 31;
   localparam int FIELD_BITS       = 31;
   localparam int ENERGY_BITS      = 62;
   localparam int DIFF_ENERGY_BITS = 63;
   localparam int CROSS_BITS       = 63;

   localparam logic [INDEX_BITS-1:0]  COUNT_MAX  = '1;
   localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;
   localparam logic [DIFF_ENERGY_BITS-1:0] DIFF_ENERGY_MAX = '1;
   localparam logic signed [63:0] PROD_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] PROD_MIN = 64'shC000_0000_0000_0000;

   typedef enum logic [1:0] {
      KIND_A    = 2'd0,
      KIND_B    = 2'd1,
      KIND_DIFF = 2'd2
   } report_kind_type;

   typedef struct packed {
      logic load;   // stage 1 takes a new word
      logic acc;    // stage 2 folds the stage 1 word into the sums
      logic clr;    // stage 1 word ends the record
   } pss_ctl_type;

   typedef struct packed {
      logic [15:0]             peak;
      logic [ENERGY_BITS-1:0]  energy;
      logic [INDEX_BITS-1:0]   hits;
      logic [INDEX_BITS-1:0]   first;
      logic [INDEX_BITS-1:0]   last;
      logic                    seen;
   } lane_stats_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]       frames;
      logic [15:0]                 peak;
      logic [DIFF_ENERGY_BITS-1:0] energy;
      logic [INDEX_BITS-1:0]       hits;
      logic [CROSS_BITS-1:0]       dot;
   } pair_stats_type;

   function automatic logic [INDEX_BITS-1:0] count_up(input logic [INDEX_BITS-1:0] c);
      logic [INDEX_BITS-1:0] nxt;
      nxt = c + 1'b1;
      return (c == COUNT_MAX) ? c : nxt;
   endfunction

   function automatic logic [FIELD_BITS-1:0] fit_field(input logic [INDEX_BITS-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

FILE: src/paired_sample_statistics_unit.sv
// Paired sample statistics. Takes one pair of signed 16-bit samples per clock
// and keeps, for each stream, peak magnitude, sum of squares, nonzero count and
// first/last nonzero index, and for the pair the differing count, sum of
// squared differences (B - A), saturated dot product and peak difference.
// Words pass a two-stage pipeline (square/product, then accumulate in the
// A, B and pair lanes): a word is registered in stage 1 when accepted and
// folded in when stage 1 next advances. A word flagged end_of_record makes
// three result words (A, B, pair) from a report buffer, the first on the cycle
// after it is folded in, and clears all sums. req_ready stays high at one word
// per clock except while an end-of-record word waits in stage 1 for the
// previous report buffer to drain. Counters saturate at their maximum.
module paired_sample_statistics_unit
   import pss_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [15:0]           req_sample_a,
   input  logic signed [15:0]           req_sample_b,
   input  logic                         req_end_of_record,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_report_kind,
   output logic [FIELD_BITS-1:0]        rsp_frame_total,
   output logic [15:0]                  rsp_peak_value,
   output logic [DIFF_ENERGY_BITS-1:0]  rsp_energy_total,
   output logic [FIELD_BITS-1:0]        rsp_hit_total,
   output logic [FIELD_BITS-1:0]        rsp_first_active,
   output logic [FIELD_BITS-1:0]        rsp_last_active,
   output logic                         rsp_any_active,
   output logic signed [CROSS_BITS-1:0] rsp_cross_sum,
   output logic                         rsp_last_of_run
);

   logic                  s1_vld_ff, s1_vld_in;
   logic                  s1_eor_ff;
   logic                  adv;
   pss_ctl_type           ctl;
   logic [INDEX_BITS-1:0] index;
   lane_stats_type        upd_a, upd_b;
   pair_stats_type        upd_p;

   // stage 1 holds only when its word ends a record and the report is busy
   always_comb begin
      adv       = !(s1_vld_ff && s1_eor_ff && rsp_valid);
      req_ready = adv;
      s1_vld_in = adv ? req_valid : s1_vld_ff;
      ctl.load  = adv;
      ctl.acc   = adv && s1_vld_ff;
      ctl.clr   = s1_eor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_eor_ff <= req_end_of_record;
      end
   end

   pss_lane u_lane_a (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_sample_a),
      .index  (index),
      .upd    (upd_a)
   );

   pss_lane u_lane_b (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_sample_b),
      .index  (index),
      .upd    (upd_b)
   );

   pss_pair u_pair (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample_a (req_sample_a),
      .sample_b (req_sample_b),
      .index    (index),
      .upd      (upd_p)
   );

   pss_report u_report (
      .clock            (clock),
      .reset            (reset),
      .load             (ctl.acc && ctl.clr),
      .lane_a           (upd_a),
      .lane_b           (upd_b),
      .pair             (upd_p),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_report_kind  (rsp_report_kind),
      .rsp_frame_total  (rsp_frame_total),
      .rsp_peak_value   (rsp_peak_value),
      .rsp_energy_total (rsp_energy_total),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_first_active (rsp_first_active),
      .rsp_last_active  (rsp_last_active),
      .rsp_any_active   (rsp_any_active),
      .rsp_cross_sum    (rsp_cross_sum),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

FILE: src/pss_lane.sv
module pss_lane
   import pss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  pss_ctl_type           ctl,
   input  logic signed [15:0]    sample,
   input  logic [INDEX_BITS-1:0] index,
   output lane_stats_type        upd
);

   logic signed [16:0] sx;
   logic signed [16:0] sx_neg;
   logic [16:0]        mag_full;
   logic [15:0]        mag_in;
   logic [31:0]        sq_in;
   logic               nz_in;

   logic [15:0]        mag_ff;
   logic [31:0]        sq_ff;
   logic               nz_ff;

   lane_stats_type     stats_ff;
   logic [ENERGY_BITS:0] sum;

   // stage 1: magnitude and square
   always_comb begin
      sx       = 17'(sample);
      sx_neg   = -sx;
      mag_full = sx[16] ? sx_neg : sx;
      mag_in   = mag_full[15:0];
      sq_in    = 32'(mag_in) * 32'(mag_in);
      nz_in    = (sample != 16'sd0);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mag_ff <= mag_in;
         sq_ff  <= sq_in;
         nz_ff  <= nz_in;
      end
   end

   // stage 2: accumulate
   always_comb begin
      sum        = {1'b0, stats_ff.energy} + (ENERGY_BITS + 1)'(sq_ff);
      upd.peak   = (mag_ff > stats_ff.peak) ? mag_ff : stats_ff.peak;
      upd.energy = sum[ENERGY_BITS] ? ENERGY_MAX : sum[ENERGY_BITS-1:0];
      upd.hits   = nz_ff ? count_up(stats_ff.hits) : stats_ff.hits;
      upd.first  = (nz_ff && !stats_ff.seen) ? index : stats_ff.first;
      upd.last   = nz_ff ? index : stats_ff.last;
      upd.seen   = stats_ff.seen | nz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
      end else if (ctl.acc) begin
         stats_ff <= ctl.clr ? '0 : upd;
      end
   end

endmodule

FILE: src/pss_pair.sv
module pss_pair
   import pss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  pss_ctl_type           ctl,
   input  logic signed [15:0]    sample_a,
   input  logic signed [15:0]    sample_b,
   output logic [INDEX_BITS-1:0] index,
   output pair_stats_type        upd
);

   logic signed [16:0] diff;
   logic signed [16:0] diff_neg;
   logic [16:0]        adiff_full;
   logic [15:0]        adiff_in;
   logic [31:0]        dsq_in;
   logic signed [31:0] prod_in;
   logic               dnz_in;

   logic [15:0]        adiff_ff;
   logic [31:0]        dsq_ff;
   logic signed [31:0] prod_ff;
   logic               dnz_ff;

   pair_stats_type     acc_ff;
   logic [63:0]        esum;
   logic signed [63:0] csum;
   logic signed [63:0] cclamp;

   // stage 1: difference, its square, and the product
   always_comb begin
      diff       = 17'(sample_b) - 17'(sample_a);
      diff_neg   = -diff;
      adiff_full = diff[16] ? diff_neg : diff;
      adiff_in   = adiff_full[15:0];
      dsq_in     = 32'(adiff_in) * 32'(adiff_in);
      prod_in    = 32'(sample_a) * 32'(sample_b);
      dnz_in     = (diff != 17'sd0);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         adiff_ff <= adiff_in;
         dsq_ff   <= dsq_in;
         prod_ff  <= prod_in;
         dnz_ff   <= dnz_in;
      end
   end

   // frame index of the word in stage 2 is the count before it
   assign index = acc_ff.frames;

   always_comb begin
      esum = {1'b0, acc_ff.energy} + 64'(dsq_ff);
      csum = $signed(64'($signed(acc_ff.dot))) + 64'(prod_ff);
      priority if (csum > PROD_MAX) begin
         cclamp = PROD_MAX;
      end else if (csum < PROD_MIN) begin
         cclamp = PROD_MIN;
      end else begin
         cclamp = csum;
      end
      upd.frames = count_up(acc_ff.frames);
      upd.peak   = (adiff_ff > acc_ff.peak) ? adiff_ff : acc_ff.peak;
      upd.energy = esum[63] ? DIFF_ENERGY_MAX : esum[DIFF_ENERGY_BITS-1:0];
      upd.hits   = dnz_ff ? count_up(acc_ff.hits) : acc_ff.hits;
      upd.dot    = cclamp[CROSS_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.acc) begin
         acc_ff <= ctl.clr ? '0 : upd;
      end
   end

endmodule

FILE: src/pss_report.sv
module pss_report
   import pss_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  lane_stats_type               lane_a,
   input  lane_stats_type               lane_b,
   input  pair_stats_type               pair,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_report_kind,
   output logic [FIELD_BITS-1:0]        rsp_frame_total,
   output logic [15:0]                  rsp_peak_value,
   output logic [DIFF_ENERGY_BITS-1:0]  rsp_energy_total,
   output logic [FIELD_BITS-1:0]        rsp_hit_total,
   output logic [FIELD_BITS-1:0]        rsp_first_active,
   output logic [FIELD_BITS-1:0]        rsp_last_active,
   output logic                         rsp_any_active,
   output logic signed [CROSS_BITS-1:0] rsp_cross_sum,
   output logic                         rsp_last_of_run
);

   lane_stats_type  snap_a_ff;
   lane_stats_type  snap_b_ff;
   pair_stats_type  snap_p_ff;
   logic            vld_ff, vld_in;
   report_kind_type kind_ff, kind_in;
   lane_stats_type  sel;

   always_ff @(posedge clock) begin
      if (load) begin
         snap_a_ff <= lane_a;
         snap_b_ff <= lane_b;
         snap_p_ff <= pair;
      end
   end

   // next state: A, B, then pair word
   always_comb begin
      vld_in  = vld_ff;
      kind_in = kind_ff;
      if (load) begin
         vld_in  = 1'b1;
         kind_in = KIND_A;
      end else if (vld_ff && rsp_ready) begin
         unique case (kind_ff)
            KIND_A:    kind_in = KIND_B;
            KIND_B:    kind_in = KIND_DIFF;
            KIND_DIFF: vld_in  = 1'b0;
            default:   vld_in  = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         kind_ff <= KIND_A;
      end else begin
         vld_ff  <= vld_in;
         kind_ff <= kind_in;
      end
   end

   // outputs
   always_comb begin
      sel              = (kind_ff == KIND_B) ? snap_b_ff : snap_a_ff;
      rsp_valid        = vld_ff;
      rsp_report_kind  = kind_ff;
      rsp_frame_total  = fit_field(snap_p_ff.frames);
      rsp_peak_value   = sel.peak;
      rsp_energy_total = {1'b0, sel.energy};
      rsp_hit_total    = fit_field(sel.hits);
      rsp_first_active = fit_field(sel.first);
      rsp_last_active  = fit_field(sel.last);
      rsp_any_active   = sel.seen;
      rsp_cross_sum    = '0;
      rsp_last_of_run  = 1'b0;
      unique case (kind_ff)
         KIND_A, KIND_B: begin
         end
         KIND_DIFF: begin
            rsp_peak_value   = snap_p_ff.peak;
            rsp_energy_total = snap_p_ff.energy;
            rsp_hit_total    = fit_field(snap_p_ff.hits);
            rsp_first_active = '0;
            rsp_last_active  = '0;
            rsp_any_active   = 1'b0;
            rsp_cross_sum    = snap_p_ff.dot;
            rsp_last_of_run  = 1'b1;
         end
         default: begin
            rsp_last_of_run  = 1'b1;
         end
      endcase
   end

endmodule

FILE: src/pss_checker.sv
module pss_checker
   import pss_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_report_kind,
   input logic       rsp_last_of_run
);

   // last word of a report is exactly the pair word
   a_last_is_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_run == (rsp_report_kind == KIND_DIFF)))
      else $error("last_of_run does not match pair word");

   // a report always opens with stream A
   a_report_starts_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_report_kind == KIND_A))
      else $error("report does not start with stream A");

   // A and B words are followed at once by the next word of the report
   a_report_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=>
         (rsp_valid && (rsp_report_kind == 2'($past(rsp_report_kind) + 2'd1))))
      else $error("report words out of order");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_report_kind)))
      else $error("result word dropped while stalled");

endmodule

bind paired_sample_statistics_unit pss_checker u_pss_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_report_kind (rsp_report_kind),
   .rsp_last_of_run (rsp_last_of_run)
);
